// File: rtl/source_token_scanner_unit_macros.svh
// Assertion macros for the source token scanner checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");

// Next-cycle implication, disabled during reset.
`define STS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");

`endif

// File: rtl/sts_pkg.sv
// Shared types, codes and character helpers of the source token scanner.
// No dependencies; used by every module of the scanner.
package sts_pkg;

	localparam int OFFSET_BITS     = 24;
	localparam int LINE_BITS       = 20;
	localparam int ACC_BITS        = 63;
	localparam int STS_QUEUE_DEPTH = 2;

	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	// token kinds
	localparam logic [3:0] K_INT   = 4'd0;
	localparam logic [3:0] K_IDENT = 4'd1;
	localparam logic [3:0] K_LET   = 4'd2;
	localparam logic [3:0] K_BOOL  = 4'd3;
	localparam logic [3:0] K_ATOM  = 4'd4;
	localparam logic [3:0] K_EQUAL = 4'd5;
	localparam logic [3:0] K_SEMI  = 4'd6;
	localparam logic [3:0] K_END   = 4'd7;
	localparam logic [3:0] K_ERROR = 4'd8;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
	localparam logic [1:0] ERR_ATOM_NAME  = 2'd2;
	localparam logic [1:0] ERR_ATOM_START = 2'd3;

	// scan modes
	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_NUMBER  = 3'd1;
	localparam logic [2:0] M_IDENT   = 3'd2;
	localparam logic [2:0] M_COLON   = 3'd3;
	localparam logic [2:0] M_ATOM    = 3'd4;
	localparam logic [2:0] M_COMMENT = 3'd5;
	localparam logic [2:0] M_DROP    = 3'd6;

	// keyword match progress
	localparam logic [3:0] KP_NONE  = 4'd0;
	localparam logic [3:0] KP_LET   = 4'd3;
	localparam logic [3:0] KP_TRUE  = 4'd7;
	localparam logic [3:0] KP_FALSE = 4'd12;
	localparam logic [3:0] KP_DEAD  = 4'd15;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       byte_present;
		logic       end_of_source;
	} src_item_t;

	typedef struct packed {
		logic [3:0]             token_kind;
		logic [1:0]             error_code;
		logic [OFFSET_BITS-1:0] start_offset;
		logic [OFFSET_BITS-1:0] token_length;
		logic [LINE_BITS-1:0]   first_line;
		logic [LINE_BITS-1:0]   first_col;
		logic [ACC_BITS-1:0]    num_value;
		logic                   truth_value;
		logic                   last_of_run;
	} tok_item_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] off;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   col;
	} pos_t;

	localparam pos_t POS_RESET = '{off: '0, line: LINE_BITS'(1), col: LINE_BITS'(1)};

	// all results caused by one input transaction
	typedef struct packed {
		tok_item_t [2:0] res;
		logic [1:0]      cnt;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_head(input logic [7:0] c);
		return is_alpha(c) || c == CH_UNDER;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_head(c) || is_digit(c);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_LF;
	endfunction

	// next expected character of "let", "true", "false"; zero at a full match
	function automatic logic [7:0] kw_next(input logic [3:0] p);
		logic [7:0] r;
		case (p)
			4'd1:    r = 8'h65;
			4'd2:    r = 8'h74;
			4'd4:    r = 8'h72;
			4'd5:    r = 8'h75;
			4'd6:    r = 8'h65;
			4'd8:    r = 8'h61;
			4'd9:    r = 8'h6C;
			4'd10:   r = 8'h73;
			4'd11:   r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kw_feed(input logic [3:0] p, input logic [7:0] c);
		logic [3:0] r;
		if (p == KP_NONE) begin
			if (c == 8'h6C)      r = 4'd1;
			else if (c == 8'h74) r = 4'd4;
			else if (c == 8'h66) r = 4'd8;
			else                 r = KP_DEAD;
		end else if (kw_next(p) != 8'h00 && kw_next(p) == c) begin
			r = 4'(p + 4'd1);
		end else begin
			r = KP_DEAD;
		end
		return r;
	endfunction

	function automatic logic [3:0] word_kind(input logic atom, input logic [3:0] kp);
		logic [3:0] r;
		if (atom)                                 r = K_ATOM;
		else if (kp == KP_LET)                    r = K_LET;
		else if (kp == KP_TRUE || kp == KP_FALSE) r = K_BOOL;
		else                                      r = K_IDENT;
		return r;
	endfunction

	function automatic tok_item_t mk_tok(
		input logic [3:0]             kind,
		input logic [1:0]             err,
		input pos_t                   st,
		input logic [OFFSET_BITS-1:0] len,
		input logic [ACC_BITS-1:0]    ival,
		input logic                   bval
	);
		tok_item_t t;
		t.token_kind   = kind;
		t.error_code   = err;
		t.start_offset = st.off;
		t.token_length = len;
		t.first_line   = st.line;
		t.first_col    = st.col;
		t.num_value    = ival;
		t.truth_value  = bval;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

endpackage

// File: rtl/sts_front.sv
// Scanner front end: accepts source bytes, keeps the lexer state and
// builds the result bundle of each transaction. Depends on sts_pkg.
module sts_front import sts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_item_t src_item,
	input  q_stat_t   q_stat,
	output logic      push,
	output bundle_t   push_data
);

	logic [2:0]          mode_q, m;
	pos_t                pos_q, pos, mv_pos;
	pos_t                st_q, st;
	logic [ACC_BITS-1:0] acc_q, acc;
	logic [3:0]          kp_q, kp;
	logic [1:0]          n;
	tok_item_t [2:0]     res;
	logic                restart;
	logic [7:0]          c;
	logic [ACC_BITS+3:0] prod;
	logic                accept;

	assign src_ready = !q_stat.full;
	assign accept    = src_valid && src_ready;
	assign c         = src_item.source_byte;

	// position after consuming c
	always_comb begin
		mv_pos = pos_q;
		if (pos_q.off != '1) mv_pos.off = pos_q.off + 1'b1;
		if (c == CH_LF) begin
			if (pos_q.line != '1) mv_pos.line = pos_q.line + 1'b1;
			mv_pos.col = LINE_BITS'(1);
		end else if (pos_q.col != '1) begin
			mv_pos.col = pos_q.col + 1'b1;
		end
	end

	// acc * 10 + digit; saturate when it passes the maximum
	assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {{ACC_BITS{1'b0}}, c[3:0]};

	always_comb begin
		m       = mode_q;
		pos     = pos_q;
		st      = st_q;
		acc     = acc_q;
		kp      = kp_q;
		n       = 2'd0;
		res     = '0;
		restart = 1'b0;
		if (src_item.byte_present) begin
			case (mode_q)
				M_NUMBER: begin
					if (is_digit(c)) begin
						acc = (prod > {4'd0, ACC_MAX}) ? ACC_MAX : prod[ACC_BITS-1:0];
						pos = mv_pos;
					end else begin
						res[n] = mk_tok(K_INT, ERR_NONE, st, pos.off - st.off, acc, 1'b0);
						n = n + 2'd1;
						m = M_IDLE;
						restart = 1'b1;
					end
				end
				M_IDENT, M_ATOM: begin
					if (is_word(c)) begin
						if (mode_q == M_IDENT) kp = kw_feed(kp_q, c);
						pos = mv_pos;
					end else begin
						res[n] = mk_tok(word_kind(mode_q == M_ATOM, kp), ERR_NONE, st,
							pos.off - st.off, '0, mode_q != M_ATOM && kp == KP_TRUE);
						n = n + 2'd1;
						m = M_IDLE;
						restart = 1'b1;
					end
				end
				M_COLON: begin
					if (is_head(c)) begin
						m = M_ATOM;
						pos = mv_pos;
					end else begin
						res[n] = mk_tok(K_ERROR, ERR_ATOM_START, st, '0, '0, 1'b0);
						n = n + 2'd1;
						m = M_DROP;
					end
				end
				M_COMMENT: begin
					pos = mv_pos;
					if (c == CH_LF) m = M_IDLE;
				end
				M_DROP: begin
				end
				default: begin
					m = M_IDLE;
					restart = 1'b1;
				end
			endcase
			if (restart) begin
				st = pos;
				if (is_blank(c)) begin
					pos = mv_pos;
				end else if (c == CH_HASH) begin
					pos = mv_pos;
					m = M_COMMENT;
				end else if (c == CH_EQUAL || c == CH_SEMI) begin
					pos = mv_pos;
					res[n] = mk_tok((c == CH_EQUAL) ? K_EQUAL : K_SEMI, ERR_NONE, st,
						pos.off - st.off, '0, 1'b0);
					n = n + 2'd1;
				end else if (c == CH_COLON) begin
					pos = mv_pos;
					m = M_COLON;
				end else if (is_digit(c)) begin
					acc = {{(ACC_BITS-4){1'b0}}, c[3:0]};
					pos = mv_pos;
					m = M_NUMBER;
				end else if (is_head(c)) begin
					kp = kw_feed(KP_NONE, c);
					pos = mv_pos;
					m = M_IDENT;
				end else begin
					res[n] = mk_tok(K_ERROR, ERR_UNEXPECTED, st, '0, '0, 1'b0);
					n = n + 2'd1;
					m = M_DROP;
				end
			end
		end
		if (src_item.end_of_source) begin
			if (m == M_NUMBER) begin
				res[n] = mk_tok(K_INT, ERR_NONE, st, pos.off - st.off, acc, 1'b0);
				n = n + 2'd1;
				m = M_IDLE;
			end else if (m == M_IDENT || m == M_ATOM) begin
				res[n] = mk_tok(word_kind(m == M_ATOM, kp), ERR_NONE, st,
					pos.off - st.off, '0, m != M_ATOM && kp == KP_TRUE);
				n = n + 2'd1;
				m = M_IDLE;
			end else if (m == M_COLON) begin
				res[n] = mk_tok(K_ERROR, ERR_ATOM_NAME, st, '0, '0, 1'b0);
				n = n + 2'd1;
				m = M_DROP;
			end
			if (m != M_DROP) begin
				st = pos;
				res[n] = mk_tok(K_END, ERR_NONE, st, '0, '0, 1'b0);
				n = n + 2'd1;
			end
			// start the next text from scratch
			m   = M_IDLE;
			pos = POS_RESET;
			st  = POS_RESET;
			acc = '0;
			kp  = KP_NONE;
		end
	end

	assign push          = accept && n != 2'd0;
	assign push_data.res = res;
	assign push_data.cnt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= POS_RESET;
			st_q   <= POS_RESET;
			acc_q  <= '0;
			kp_q   <= KP_NONE;
		end else if (accept) begin
			mode_q <= m;
			pos_q  <= pos;
			st_q   <= st;
			acc_q  <= acc;
			kp_q   <= kp;
		end
	end

endmodule

// File: rtl/sts_queue.sv
// Result bundle queue between scanner front end and output back end.
// Depends on sts_pkg for the bundle and status types.
module sts_queue import sts_pkg::*; #(
	parameter int DEPTH = STS_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wdata,
	input  logic    pop,
	output bundle_t rdata,
	output q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign rdata        = mem_q[rd_q];
	assign q_stat.full  = cnt_q == CW'(DEPTH);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/sts_back.sv
// Output back end: takes one result bundle at a time from the queue and
// hands its results out one per transaction. Depends on sts_pkg.
module sts_back import sts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  bundle_t   head,
	output logic      pop,
	output logic      tok_valid,
	input  logic      tok_ready,
	output tok_item_t tok_item
);

	bundle_t    bnd_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       take, last, fin;

	assign take = busy_q && tok_ready;
	assign last = (idx_q + 2'd1) == bnd_q.cnt;
	assign fin  = take && last;
	// refill when idle, or in the cycle the last result of the held bundle leaves
	assign pop  = (!busy_q || fin) && !q_stat.empty;

	always_comb begin
		tok_item             = bnd_q.res[idx_q];
		tok_item.last_of_run = last;
	end
	assign tok_valid = busy_q;

	always_ff @(posedge clk) begin
		if (pop) bnd_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/source_token_scanner_unit.sv
// Streaming lexer: one source byte per transaction in, tokens out.
// Takes one input transaction per cycle while the bundle queue has room.
// Results leave one per cycle while tok_ready is high; the first result of a transaction is
// written to the bundle queue, then loaded into the back end before it is offered.
// Reset, and every end mark, return the scanner to idle at offset 0, line 1, column 1.
module source_token_scanner_unit import sts_pkg::*; #(
	parameter int QUEUE_DEPTH = STS_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_item_t src_item,
	output logic      tok_valid,
	input  logic      tok_ready,
	output tok_item_t tok_item
);

	q_stat_t q_stat;
	logic    push, pop;
	bundle_t push_data, head;

	sts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	sts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (head),
		.q_stat (q_stat)
	);

	sts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

// File: rtl/sts_checker.sv
// Port-level checks of the source token scanner, bound to the top level.
// Depends on sts_pkg and source_token_scanner_unit_macros.svh.
`include "source_token_scanner_unit_macros.svh"

module sts_checker import sts_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_ready,
	input src_item_t src_item,
	input logic      tok_valid,
	input logic      tok_ready,
	input tok_item_t tok_item
);

	// hold a stalled result
	`STS_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready, tok_valid && $stable(tok_item))
	// end tokens carry no length and no error
	`STS_ASSERT_IMPL(a_end_shape, tok_valid && tok_item.token_kind == K_END, tok_item.token_length == '0 && tok_item.error_code == ERR_NONE)
	// error results carry a cause and no length
	`STS_ASSERT_IMPL(a_err_shape, tok_valid && tok_item.token_kind == K_ERROR, tok_item.error_code != ERR_NONE && tok_item.token_length == '0)
	// positions count from one
	`STS_ASSERT_IMPL(a_pos_base, tok_valid, tok_item.first_line != '0 && tok_item.first_col != '0)

endmodule

bind source_token_scanner_unit sts_checker u_sts_checker (.*);
